/* hw/rtl/torus_surface_normal_defines.svh */
// Assertion macros shared by the torus normal checker.
`ifndef TORUS_SURFACE_NORMAL_DEFINES_SVH
`define TORUS_SURFACE_NORMAL_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define TSN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define TSN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/tsn_pkg.sv */
// Types and constants of the torus surface normal block.
package tsn_pkg;

	localparam int PT_W    = 32;
	localparam int ROOT_W  = 32;
	localparam int RAD_W   = 31;
	localparam int QUO_W   = 31;
	localparam int AXC_W   = 21;
	localparam int AXIS_W  = 63;
	localparam int CX_W    = 34;
	localparam int LATENCY = 71;

	localparam logic [1:0] REG_RADIUS = 2'd0;
	localparam logic [1:0] REG_AXIS_U = 2'd1;
	localparam logic [1:0] REG_AXIS_V = 2'd2;
	localparam logic [1:0] REG_AXIS_W = 2'd3;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} pt_t;

	typedef struct packed {
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic               on_axis;
		logic               saturated;
	} res_t;

	typedef struct packed {
		logic signed [CX_W-1:0] cx;
		logic signed [CX_W-1:0] cy;
		logic signed [31:0]     z;
		logic                   on_axis;
	} corr_t;

endpackage

/* hw/rtl/torus_surface_normal.sv */
// Torus surface normal: top level with config registers and front stages.
//
// Usage:
//   Pulse start with a hit point (object coordinates, signed Q16.16) on
//   point; the beat is taken at any edge where start is high and busy is
//   low. busy stays low: the pipeline takes one hit point every cycle.
//   Each beat yields exactly one result on normal, flagged by done for a
//   single cycle. The chain is three front stages (abs, squares, sum),
//   32 square-root stages of two radicand bits each, one R*|v| multiply
//   stage, 31 restoring divide stages (one quotient bit each), one
//   subtract stage and three stages for rotation, floor scaling and
//   saturation.
//   The receiver cannot stall; results are shown once and must be taken.
//   Configuration beats on cfg_valid/cfg_ready/cfg_index/cfg_data are
//   always taken; write them only while no point is in flight.
//   Reset clears all valid bits and the registers (radius and axes = 0).
module torus_surface_normal import tsn_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  pt_t         point,
	output logic        done,
	output res_t        normal,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [RAD_W-1:0]  major_radius_q;
	logic [AXIS_W-1:0] axis_u_q, axis_v_q, axis_w_q;

	logic [PT_W-1:0]   ax, ay;
	logic              acc;

	logic              v_s1, v_s2, v_s3;
	pt_t               side_s1, side_s2, side_s3;
	logic [PT_W-1:0]   ax_s1, ay_s1;
	logic [63:0]       sqx_s2, sqy_s2;
	logic [63:0]       rad_s3;

	logic              sq_v;
	pt_t               sq_side;
	logic [ROOT_W-1:0] sq_root;

	logic              rd_v;
	corr_t             rd_corr;

	// Every cycle can take a point and a config beat.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign acc       = start && !busy;

	// Config register file; high bits past each register width drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_radius_q <= '0;
			axis_u_q       <= '0;
			axis_v_q       <= '0;
			axis_w_q       <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RADIUS: major_radius_q <= cfg_data[RAD_W-1:0];
				REG_AXIS_U: axis_u_q       <= cfg_data[AXIS_W-1:0];
				REG_AXIS_V: axis_v_q       <= cfg_data[AXIS_W-1:0];
				REG_AXIS_W: axis_w_q       <= cfg_data[AXIS_W-1:0];
				default:    major_radius_q <= major_radius_q;
			endcase
		end
	end

	// Magnitudes of x and y; the most negative value maps to 2^31.
	always_comb begin
		ax = point.point_x[PT_W-1] ? (~point.point_x + 1'b1) : point.point_x;
		ay = point.point_y[PT_W-1] ? (~point.point_y + 1'b1) : point.point_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Advance the radicand x*x + y*y over three stages.
	always_ff @(posedge clk) begin
		side_s1 <= point;
		ax_s1   <= ax;
		ay_s1   <= ay;
		side_s2 <= side_s1;
		sqx_s2  <= ax_s1 * ax_s1;
		sqy_s2  <= ay_s1 * ay_s1;
		side_s3 <= side_s2;
		rad_s3  <= sqx_s2 + sqy_s2;
	end

	tsn_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_v     (v_s3),
		.in_side  (side_s3),
		.rad      (rad_s3),
		.out_v    (sq_v),
		.out_side (sq_side),
		.root     (sq_root)
	);

	tsn_radial u_radial (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_v         (sq_v),
		.in_side      (sq_side),
		.root         (sq_root),
		.major_radius (major_radius_q),
		.out_v        (rd_v),
		.corr         (rd_corr)
	);

	tsn_xform #(
		.FRAC_BITS (FRAC_BITS)
	) u_xform (
		.clk    (clk),
		.arst_n (arst_n),
		.in_v   (rd_v),
		.corr   (rd_corr),
		.axis_u (axis_u_q),
		.axis_v (axis_v_q),
		.axis_w (axis_w_q),
		.done   (done),
		.normal (normal)
	);

endmodule

/* hw/rtl/tsn_isqrt.sv */
// Pipelined floor square root, two radicand bits per stage.
module tsn_isqrt import tsn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_v,
	input  pt_t               in_side,
	input  logic [63:0]       rad,
	output logic              out_v,
	output pt_t               out_side,
	output logic [ROOT_W-1:0] root
);

	logic              vld_s  [1:ROOT_W];
	pt_t               side_s [1:ROOT_W];
	logic [33:0]       rem_s  [1:ROOT_W];
	logic [ROOT_W-1:0] root_s [1:ROOT_W];
	logic [63:0]       rad_s  [1:ROOT_W];

	genvar k;
	for (k = 0; k < ROOT_W; k++) begin : g_stage
		logic              v_in;
		pt_t               side_in;
		logic [33:0]       rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [63:0]       rad_in;
		logic [33:0]       cand;
		logic [33:0]       trial;

		if (k == 0) begin : g_first
			assign v_in    = in_v;
			assign side_in = in_side;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
		end else begin : g_next
			assign v_in    = vld_s[k];
			assign side_in = side_s[k];
			assign rem_in  = rem_s[k];
			assign root_in = root_s[k];
			assign rad_in  = rad_s[k];
		end

		always_comb begin
			cand  = {rem_in[31:0], rad_in[63:62]};
			trial = {root_in, 2'b01};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			side_s[k+1] <= side_in;
			rad_s[k+1]  <= {rad_in[61:0], 2'b00};
			if (cand >= trial) begin
				rem_s[k+1]  <= cand - trial;
				root_s[k+1] <= {root_in[ROOT_W-2:0], 1'b1};
			end else begin
				rem_s[k+1]  <= cand;
				root_s[k+1] <= {root_in[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign out_v    = vld_s[ROOT_W];
	assign out_side = side_s[ROOT_W];
	assign root     = root_s[ROOT_W];

endmodule

/* hw/rtl/tsn_radial.sv */
// Radial correction: R*|v| product, pipelined division by d, subtract.
module tsn_radial import tsn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_v,
	input  pt_t               in_side,
	input  logic [ROOT_W-1:0] root,
	input  logic [RAD_W-1:0]  major_radius,
	output logic              out_v,
	output corr_t             corr
);

	localparam int PROD_W = RAD_W + PT_W;

	logic [PT_W-1:0] ax, ay;

	logic                        v_s1;
	pt_t                         side_s1;
	logic [ROOT_W-1:0]           d_s1;
	logic                        zero_s1;
	logic [1:0][PROD_W-1:0]      prod_s1;

	logic                        vld_s  [2:QUO_W+1];
	pt_t                         side_s [2:QUO_W+1];
	logic [ROOT_W-1:0]           d_s    [2:QUO_W+1];
	logic                        zero_s [2:QUO_W+1];
	logic [1:0][ROOT_W-1:0]      rem_s  [2:QUO_W+1];
	logic [1:0][QUO_W-1:0]       lo_s   [2:QUO_W+1];
	logic [1:0][QUO_W-1:0]       quo_s  [2:QUO_W+1];

	logic                        v_s33;
	corr_t                       corr_s33;

	logic [QUO_W-1:0]            qx, qy;
	logic signed [CX_W-1:0]      x_ext, y_ext;

	always_comb begin
		ax = in_side.point_x[PT_W-1] ? (~in_side.point_x + 1'b1) : in_side.point_x;
		ay = in_side.point_y[PT_W-1] ? (~in_side.point_y + 1'b1) : in_side.point_y;
	end

	// Multiply stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		side_s1    <= in_side;
		d_s1       <= root;
		zero_s1    <= (root == '0);
		prod_s1[0] <= major_radius * ax;
		prod_s1[1] <= major_radius * ay;
	end

	// Restoring division; the quotient never exceeds R, so the top half starts as remainder.
	genvar j;
	for (j = 0; j < QUO_W; j++) begin : g_div
		logic                   v_in;
		pt_t                    side_in;
		logic [ROOT_W-1:0]      d_in;
		logic                   zero_in;
		logic [1:0][ROOT_W-1:0] rem_in;
		logic [1:0][QUO_W-1:0]  lo_in;
		logic [1:0][QUO_W-1:0]  quo_in;
		logic [1:0][ROOT_W-1:0] rem_nx;
		logic [1:0][QUO_W-1:0]  lo_nx;
		logic [1:0][QUO_W-1:0]  quo_nx;
		logic [ROOT_W:0]        cand;

		if (j == 0) begin : g_first
			assign v_in      = v_s1;
			assign side_in   = side_s1;
			assign d_in      = d_s1;
			assign zero_in   = zero_s1;
			assign rem_in[0] = prod_s1[0][PROD_W-1:QUO_W];
			assign rem_in[1] = prod_s1[1][PROD_W-1:QUO_W];
			assign lo_in[0]  = prod_s1[0][QUO_W-1:0];
			assign lo_in[1]  = prod_s1[1][QUO_W-1:0];
			assign quo_in    = '0;
		end else begin : g_next
			assign v_in    = vld_s[j+1];
			assign side_in = side_s[j+1];
			assign d_in    = d_s[j+1];
			assign zero_in = zero_s[j+1];
			assign rem_in  = rem_s[j+1];
			assign lo_in   = lo_s[j+1];
			assign quo_in  = quo_s[j+1];
		end

		always_comb begin
			cand = '0;
			for (int l = 0; l < 2; l++) begin
				cand     = {rem_in[l], lo_in[l][QUO_W-1]};
				lo_nx[l] = {lo_in[l][QUO_W-2:0], 1'b0};
				if (cand >= {1'b0, d_in}) begin
					rem_nx[l] = ROOT_W'(cand - {1'b0, d_in});
					quo_nx[l] = {quo_in[l][QUO_W-2:0], 1'b1};
				end else begin
					rem_nx[l] = cand[ROOT_W-1:0];
					quo_nx[l] = {quo_in[l][QUO_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+2] <= 1'b0;
			end else begin
				vld_s[j+2] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			side_s[j+2] <= side_in;
			d_s[j+2]    <= d_in;
			zero_s[j+2] <= zero_in;
			rem_s[j+2]  <= rem_nx;
			lo_s[j+2]   <= lo_nx;
			quo_s[j+2]  <= quo_nx;
		end
	end

	// Subtract stage: move toward the tube center unless on the axis.
	always_comb begin
		qx    = quo_s[QUO_W+1][0];
		qy    = quo_s[QUO_W+1][1];
		x_ext = CX_W'(side_s[QUO_W+1].point_x);
		y_ext = CX_W'(side_s[QUO_W+1].point_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s33 <= 1'b0;
		end else begin
			v_s33 <= vld_s[QUO_W+1];
		end
	end

	always_ff @(posedge clk) begin
		corr_s33.z       <= side_s[QUO_W+1].point_z;
		corr_s33.on_axis <= zero_s[QUO_W+1];
		if (zero_s[QUO_W+1]) begin
			corr_s33.cx <= x_ext;
			corr_s33.cy <= y_ext;
		end else begin
			corr_s33.cx <= x_ext[CX_W-1] ? x_ext + $signed({3'b000, qx})
			                             : x_ext - $signed({3'b000, qx});
			corr_s33.cy <= y_ext[CX_W-1] ? y_ext + $signed({3'b000, qy})
			                             : y_ext - $signed({3'b000, qy});
		end
	end

	assign out_v = v_s33;
	assign corr  = corr_s33;

endmodule

/* hw/rtl/tsn_xform.sv */
// Object-to-world rotation, floor scaling and saturation.
module tsn_xform import tsn_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_v,
	input  corr_t             corr,
	input  logic [AXIS_W-1:0] axis_u,
	input  logic [AXIS_W-1:0] axis_v,
	input  logic [AXIS_W-1:0] axis_w,
	output logic              done,
	output res_t              normal
);

	localparam int MUL_W = CX_W + AXC_W;
	localparam int SUM_W = MUL_W + 2;
	localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
	localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-64'sd2147483648);

	logic signed [CX_W-1:0]  src [3];
	logic signed [AXC_W-1:0] cu  [3];
	logic signed [AXC_W-1:0] cv  [3];
	logic signed [AXC_W-1:0] cw  [3];

	logic                    v_s1, v_s2, v_s3;
	logic                    axis_s1, axis_s2;
	logic signed [MUL_W-1:0] prod_s1 [3][3];
	logic signed [SUM_W-1:0] sum_s2  [3];
	logic signed [SUM_W-1:0] shf     [3];
	logic signed [31:0]      comp    [3];
	logic [2:0]              clip;
	res_t                    res_s3;

	always_comb begin
		src[0] = corr.cx;
		src[1] = corr.cy;
		src[2] = CX_W'(corr.z);
		for (int c = 0; c < 3; c++) begin
			cu[c] = axis_u[AXC_W*c +: AXC_W];
			cv[c] = axis_v[AXC_W*c +: AXC_W];
			cw[c] = axis_w[AXC_W*c +: AXC_W];
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			shf[c]  = sum_s2[c] >>> FRAC_BITS;
			clip[c] = 1'b0;
			if (shf[c] > SAT_MAX) begin
				comp[c] = 32'sh7FFF_FFFF;
				clip[c] = 1'b1;
			end else if (shf[c] < SAT_MIN) begin
				comp[c] = 32'sh8000_0000;
				clip[c] = 1'b1;
			end else begin
				comp[c] = shf[c][31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		axis_s1 <= corr.on_axis;
		axis_s2 <= axis_s1;
		for (int c = 0; c < 3; c++) begin
			prod_s1[c][0] <= src[0] * cu[c];
			prod_s1[c][1] <= src[1] * cv[c];
			prod_s1[c][2] <= src[2] * cw[c];
			sum_s2[c]     <= SUM_W'(prod_s1[c][0]) + SUM_W'(prod_s1[c][1])
			               + SUM_W'(prod_s1[c][2]);
		end
		res_s3.normal_x  <= comp[0];
		res_s3.normal_y  <= comp[1];
		res_s3.normal_z  <= comp[2];
		res_s3.on_axis   <= axis_s2;
		res_s3.saturated <= |clip;
	end

	assign done   = v_s3;
	assign normal = res_s3;

endmodule

/* hw/rtl/tsn_checker.sv */
// Port-level checker for the torus normal block and its bind.
`include "torus_surface_normal_defines.svh"

module tsn_checker import tsn_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input res_t normal
);

	`TSN_ASSERT(a_never_busy, !busy, "busy raised")
	`TSN_ASSERT_NEXT(a_beat_yields_result, start && !busy, ##(LATENCY-1) done, "result missing")
	`TSN_ASSERT(a_result_has_beat, !done || $past(start && !busy, LATENCY), "spurious result")
	`TSN_ASSERT(a_sat_at_limit, !(done && normal.saturated) || normal.normal_x == 32'sh7FFF_FFFF || normal.normal_x == 32'sh8000_0000 || normal.normal_y == 32'sh7FFF_FFFF || normal.normal_y == 32'sh8000_0000 || normal.normal_z == 32'sh7FFF_FFFF || normal.normal_z == 32'sh8000_0000, "clip flag without clipped component")

endmodule

bind torus_surface_normal tsn_checker u_tsn_checker (.*);
